// File: rtl/segment_state_tracker_top_defines.svh
// Assertion macros used by the segment state tracker top module.
`ifndef SEGMENT_STATE_TRACKER_TOP_DEFINES_SVH
`define SEGMENT_STATE_TRACKER_TOP_DEFINES_SVH

// Same-cycle implication on clk, masked while arst_n is low.
`define SST_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication on clk, masked while arst_n is low.
`define SST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/sst_pkg.sv
// Types, codes and constants for the segment state tracker.
package sst_pkg;

	localparam int MAX_SEGMENTS_DEF = 1024;

	localparam int ACT_W   = 3;
	localparam int SEG_W   = 10;
	localparam int SC_W    = 11;
	localparam int SB_W    = 31;
	localparam int MB_W    = 41;
	localparam int BASE_W  = 48;
	localparam int OFF_W   = SEG_W + SB_W;
	localparam int PROT_W  = 3;
	localparam int FLAG_W  = 3;
	localparam int CFG_W   = 48;
	localparam int CFGI_W  = 3;
	localparam int CMP_W   = 17;

	// Flag bit positions
	localparam int FL_MAPPED   = 0;
	localparam int FL_DIRTY    = 1;
	localparam int FL_NEEDREAD = 2;
	localparam logic [FLAG_W-1:0] FLAGS_RESET = 3'b100;

	// Protection bits
	localparam int PROT_WR_BIT = 1;
	localparam logic [PROT_W-1:0] PROT_NO_ACCESS = 3'b000;

	localparam logic [1:0] ACC_NONE = 2'd0;
	localparam logic [1:0] ACC_RO   = 2'd1;
	localparam logic [1:0] ACC_RW   = 2'd2;
	localparam logic [1:0] ACC_KEEP = 2'd3;

	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_NOACC = 2'd1;
	localparam logic [1:0] ERR_WRITE = 2'd2;
	localparam logic [1:0] ERR_RANGE = 2'd3;

	// Flush with unmap releases the segment
	localparam logic FLUSH_RELEASE = 1'b1;

	typedef enum logic [ACT_W-1:0] {
		ACT_FAULT  = 3'd0,
		ACT_FLUSH  = 3'd1,
		ACT_DROP   = 3'd2,
		ACT_MARK   = 3'd3,
		ACT_INIT   = 3'd4,
		ACT_STATUS = 3'd5
	} action_t;

	typedef enum logic [CFGI_W-1:0] {
		REG_SEG_COUNT     = 3'd0,
		REG_SEG_BYTES     = 3'd1,
		REG_MAP_BYTES     = 3'd2,
		REG_STORAGE_BASE  = 3'd3,
		REG_PROTECTION    = 3'd4,
		REG_THREAD_SAFE   = 3'd5,
		REG_NO_FIRST_READ = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic              load;
		logic              wb;
		logic              rel;
		logic              notify;
		logic [1:0]        acc;
		logic [1:0]        old_st;
		logic [FLAG_W-1:0] nxt_st;
		logic [1:0]        err;
	} cmd_t;

endpackage

// File: rtl/sst_flag_store.sv
// Per-segment flag memory with post-reset clearing sweep and write forwarding.
module sst_flag_store #(
	parameter int DEPTH = sst_pkg::MAX_SEGMENTS_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [sst_pkg::FLAG_W-1:0] wr_data,
	output logic [sst_pkg::FLAG_W-1:0] rd_data,
	output logic                      busy
);
	import sst_pkg::*;

	logic [FLAG_W-1:0] mem [DEPTH];
	logic [FLAG_W-1:0] rdata_q;
	logic [AW-1:0]     rd_addr_q;
	logic [AW-1:0]     clr_addr_q;
	logic              clr_busy_q;
	logic [AW-1:0]     byp_addr_q;
	logic [FLAG_W-1:0] byp_data_q;
	logic              byp_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			byp_vld_q  <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
			end
			if (wr_en) begin
				byp_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= FLAGS_RESET;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q   <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
		if (wr_en) begin
			byp_addr_q <= wr_addr;
			byp_data_q <= wr_data;
		end
	end

	// The latest write wins over a read that raced it at the same edge
	assign rd_data = (byp_vld_q && (byp_addr_q == rd_addr_q)) ? byp_data_q : rdata_q;
	assign busy    = clr_busy_q;

endmodule

// File: rtl/sst_decide.sv
// Flag update and command decode for one segment transaction.
module sst_decide (
	input  sst_pkg::action_t           action,
	input  logic                       in_range,
	input  logic                       is_write,
	input  logic                       unmap,
	input  logic [sst_pkg::FLAG_W-1:0] flags,
	input  logic [sst_pkg::PROT_W-1:0] protection,
	input  logic                       thread_safe,
	input  logic                       no_first_read,
	output sst_pkg::cmd_t              cmd
);
	import sst_pkg::*;

	logic [FLAG_W-1:0] nf;
	logic              mapped;
	logic              dirty;

	assign mapped = flags[FL_MAPPED];
	assign dirty  = flags[FL_DIRTY];

	always_comb begin
		cmd     = '0;
		cmd.acc = ACC_KEEP;
		nf      = flags;
		case (action)
			ACT_FAULT: begin
				if (protection == PROT_NO_ACCESS) begin
					cmd.err = ERR_NOACC;
				end else if (is_write && !protection[PROT_WR_BIT]) begin
					cmd.err = ERR_WRITE;
				end else if (mapped && (dirty == is_write)) begin
					cmd.err = ERR_OK;
				end else begin
					cmd.load   = !mapped && flags[FL_NEEDREAD];
					cmd.acc    = is_write ? ACC_RW : ACC_RO;
					cmd.notify = 1'b1;
					nf[FL_MAPPED] = 1'b1;
					if (is_write) begin
						nf[FL_DIRTY] = 1'b1;
					end
				end
			end
			ACT_FLUSH: begin
				if (mapped && dirty) begin
					cmd.wb         = 1'b1;
					nf[FL_DIRTY]    = 1'b0;
					nf[FL_NEEDREAD] = 1'b1;
					if (thread_safe) begin
						cmd.acc = ACC_RO;
					end
				end
				if (mapped) begin
					if (unmap == FLUSH_RELEASE) begin
						cmd.acc       = ACC_NONE;
						cmd.rel       = 1'b1;
						nf[FL_MAPPED] = 1'b0;
					end else if (!thread_safe) begin
						cmd.acc = ACC_RO;
					end
				end
			end
			ACT_DROP: begin
				if (mapped && !dirty) begin
					cmd.acc       = ACC_NONE;
					cmd.rel       = 1'b1;
					nf[FL_MAPPED] = 1'b0;
				end
			end
			ACT_MARK: begin
				if (mapped && !dirty && protection[PROT_WR_BIT]) begin
					cmd.acc      = ACC_RW;
					nf[FL_DIRTY] = 1'b1;
				end
			end
			ACT_INIT: begin
				nf      = no_first_read ? '0 : FLAGS_RESET;
				cmd.acc = ACC_NONE;
			end
			default: begin
				nf = flags;
			end
		endcase
		cmd.old_st = flags[1:0];
		cmd.nxt_st = nf;
		// Out of range overrides everything: no commands, zero status
		if (!in_range) begin
			cmd     = '0;
			cmd.acc = ACC_KEEP;
			cmd.err = ERR_RANGE;
		end
	end

endmodule

// File: rtl/sst_xfer.sv
// Storage offset and clipped transfer length for a load or write back.
module sst_xfer (
	input  logic                       xfer,
	input  logic [sst_pkg::OFF_W-1:0]  seg_off,
	input  logic [sst_pkg::BASE_W-1:0] storage_base,
	input  logic [sst_pkg::SB_W-1:0]   segment_bytes,
	input  logic [sst_pkg::MB_W-1:0]   map_bytes,
	output logic [sst_pkg::BASE_W-1:0] storage_offset,
	output logic [sst_pkg::SB_W-1:0]   transfer_length
);
	import sst_pkg::*;

	logic [MB_W-1:0] remain;

	assign remain = map_bytes - MB_W'(seg_off);

	always_comb begin
		storage_offset  = '0;
		transfer_length = '0;
		if (xfer) begin
			storage_offset = storage_base + BASE_W'(seg_off);
			if (MB_W'(seg_off) >= map_bytes) begin
				transfer_length = '0;
			end else if (remain >= MB_W'(segment_bytes)) begin
				transfer_length = segment_bytes;
			end else begin
				// remain is below segment_bytes here, so it fits
				transfer_length = remain[SB_W-1:0];
			end
		end
	end

endmodule

// File: rtl/segment_state_tracker_top.sv
// Segment state tracker: per-segment mapped/dirty/need-read flags and pager commands.
// Pipeline: an accepted transaction passes stage 1, stage 2 and the output register before out_valid.
// Throughput: one transaction per cycle while out_ready holds and no clearing sweep runs; the flag memory has
// one read and one write port, with write forwarding. Reset: asynchronous; config returns to defaults,
// then a clearing sweep sets every segment's flags while in_ready stays low.
`include "segment_state_tracker_top_defines.svh"
module segment_state_tracker_top #(
	parameter int MAX_SEGMENTS = sst_pkg::MAX_SEGMENTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [sst_pkg::CFGI_W-1:0] cfg_idx,
	input  logic [sst_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [sst_pkg::ACT_W-1:0]  action,
	input  logic [sst_pkg::SEG_W-1:0]  segment,
	input  logic                       is_write,
	input  logic                       unmap,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       load_segment,
	output logic                       write_back,
	output logic                       release_res,
	output logic [1:0]                 access,
	output logic [sst_pkg::BASE_W-1:0] storage_offset,
	output logic [sst_pkg::SB_W-1:0]   transfer_length,
	output logic                       notify_touch,
	output logic [1:0]                 old_status,
	output logic [sst_pkg::FLAG_W-1:0] new_status,
	output logic [1:0]                 error
);
	import sst_pkg::*;

	localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

	// Configuration registers
	logic [SC_W-1:0]   segment_count_q;
	logic [SB_W-1:0]   segment_bytes_q;
	logic [MB_W-1:0]   map_bytes_q;
	logic [BASE_W-1:0] storage_base_q;
	logic [PROT_W-1:0] protection_q;
	logic              thread_safe_q;
	logic              no_first_read_q;

	// Stage 1: transaction plus flag read
	logic              s1_vld_q;
	action_t           act_s1;
	logic [SEG_W-1:0]  seg_s1;
	logic              wr_s1;
	logic              unmap_s1;

	// Stage 2: decision plus segment offset
	logic              s2_vld_q;
	cmd_t              cmd_s2;
	logic [OFF_W-1:0]  off_s2;

	logic              out_vld_q;
	cmd_t              cmd_q;
	logic [BASE_W-1:0] sto_q;
	logic [SB_W-1:0]   len_q;

	logic              clr_busy;
	logic              in_acc;
	logic              s2_ld;
	logic              out_ld;
	logic              in_range_s1;
	logic [FLAG_W-1:0] flags_s1;
	cmd_t              cmd_s1;
	logic [BASE_W-1:0] sto_c;
	logic [SB_W-1:0]   len_c;

	assign out_ld   = s2_vld_q && (!out_vld_q || out_ready);
	assign s2_ld    = s1_vld_q && (!s2_vld_q || out_ld);
	assign in_ready = !clr_busy && (!s1_vld_q || s2_ld);
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segment_count_q <= SC_W'(1024);
			segment_bytes_q <= SB_W'(4096);
			map_bytes_q     <= MB_W'(4194304);
			storage_base_q  <= '0;
			protection_q    <= 3'b011;
			thread_safe_q   <= 1'b1;
			no_first_read_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_SEG_COUNT:     segment_count_q <= cfg_wdata[SC_W-1:0];
				REG_SEG_BYTES:     segment_bytes_q <= cfg_wdata[SB_W-1:0];
				REG_MAP_BYTES:     map_bytes_q     <= cfg_wdata[MB_W-1:0];
				REG_STORAGE_BASE:  storage_base_q  <= cfg_wdata[BASE_W-1:0];
				REG_PROTECTION:    protection_q    <= cfg_wdata[PROT_W-1:0];
				REG_THREAD_SAFE:   thread_safe_q   <= cfg_wdata[0];
				REG_NO_FIRST_READ: no_first_read_q <= cfg_wdata[0];
				default:           segment_count_q <= segment_count_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q  <= 1'b0;
			s2_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (in_acc) begin
				s1_vld_q <= 1'b1;
			end else if (s2_ld) begin
				s1_vld_q <= 1'b0;
			end
			if (s2_ld) begin
				s2_vld_q <= 1'b1;
			end else if (out_ld) begin
				s2_vld_q <= 1'b0;
			end
			if (out_ld) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_s1   <= action_t'(action);
			seg_s1   <= segment;
			wr_s1    <= is_write;
			unmap_s1 <= unmap;
		end
		if (s2_ld) begin
			cmd_s2 <= cmd_s1;
			off_s2 <= OFF_W'(seg_s1) * OFF_W'(segment_bytes_q);
		end
		if (out_ld) begin
			cmd_q <= cmd_s2;
			sto_q <= sto_c;
			len_q <= len_c;
		end
	end

	assign in_range_s1 = (CMP_W'(seg_s1) < CMP_W'(segment_count_q)) &&
		(CMP_W'(seg_s1) < CMP_W'(MAX_SEGMENTS));

	sst_flag_store #(
		.DEPTH (MAX_SEGMENTS),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc),
		.rd_addr (AW'(segment)),
		.wr_en   (s2_ld && in_range_s1),
		.wr_addr (AW'(seg_s1)),
		.wr_data (cmd_s1.nxt_st),
		.rd_data (flags_s1),
		.busy    (clr_busy)
	);

	sst_decide u_decide (
		.action        (act_s1),
		.in_range      (in_range_s1),
		.is_write      (wr_s1),
		.unmap         (unmap_s1),
		.flags         (flags_s1),
		.protection    (protection_q),
		.thread_safe   (thread_safe_q),
		.no_first_read (no_first_read_q),
		.cmd           (cmd_s1)
	);

	sst_xfer u_xfer (
		.xfer            (cmd_s2.load || cmd_s2.wb),
		.seg_off         (off_s2),
		.storage_base    (storage_base_q),
		.segment_bytes   (segment_bytes_q),
		.map_bytes       (map_bytes_q),
		.storage_offset  (sto_c),
		.transfer_length (len_c)
	);

	assign out_valid       = out_vld_q;
	assign load_segment    = cmd_q.load;
	assign write_back      = cmd_q.wb;
	assign release_res     = cmd_q.rel;
	assign access          = cmd_q.acc;
	assign storage_offset  = sto_q;
	assign transfer_length = len_q;
	assign notify_touch    = cmd_q.notify;
	assign old_status      = cmd_q.old_st;
	assign new_status      = cmd_q.nxt_st;
	assign error           = cmd_q.err;

	`SST_ASSERT_NOW(a_no_accept_in_sweep, clr_busy, !in_ready, "transaction accepted during clearing sweep")
	`SST_ASSERT_NOW(a_range_quiet, out_valid && (error == ERR_RANGE), !load_segment && !write_back && !release_res && (old_status == 2'b00) && (new_status == '0), "out-of-range result carries commands or status")
	`SST_ASSERT_NOW(a_idle_xfer_zero, out_valid && !load_segment && !write_back, (storage_offset == '0) && (transfer_length == '0), "offset or length set without a transfer")
	`SST_ASSERT_NOW(a_wb_needs_dirty, out_valid && write_back, (old_status == 2'b11) && (error == ERR_OK), "write back of a segment that was not mapped and dirty")

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the segment state tracker: directed corners, random traffic, backpressure.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sst_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 10;
	// Spare action codes; the block treats them as a status read
	localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 3'd6;
	localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic              load;
		logic              wb;
		logic              rel;
		logic [1:0]        acc;
		logic [BASE_W-1:0] offset;
		logic [SB_W-1:0]   len;
		logic              notify;
		logic [1:0]        old_st;
		logic [FLAG_W-1:0] new_st;
		logic [1:0]        err;
	} pager_cmd_t;

	typedef struct packed {
		logic [SC_W-1:0]   seg_count;
		logic [SB_W-1:0]   seg_bytes;
		logic [MB_W-1:0]   map_bytes;
		logic [BASE_W-1:0] base;
		logic [PROT_W-1:0] prot;
		logic              thread_safe;
		logic              no_first_read;
	} region_cfg_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CFGI_W-1:0]   cfg_idx = '0;
	logic [CFG_W-1:0]    cfg_wdata = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [ACT_W-1:0]    action = '0;
	logic [SEG_W-1:0]    segment = '0;
	logic                is_write = 1'b0;
	logic                unmap = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                load_segment;
	logic                write_back;
	logic                release_res;
	logic [1:0]          access;
	logic [BASE_W-1:0]   storage_offset;
	logic [SB_W-1:0]     transfer_length;
	logic                notify_touch;
	logic [1:0]          old_status;
	logic [FLAG_W-1:0]   new_status;
	logic [1:0]          error;

	logic [FLAG_W-1:0]   seg_flags [MAX_SEGMENTS_DEF];
	region_cfg_t         cur_cfg;
	pager_cmd_t          expected_cmds [$];
	int                  mismatch_count = 0;
	int                  results_seen = 0;
	int                  cycle_count = 0;
	int                  send_idle_pct = 0;
	int                  recv_stall_pct = 0;
	int                  hold_off_cycles = 0;

	segment_state_tracker_top u_top (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic pager_cmd_t predict_pager_cmd(logic [ACT_W-1:0] act, logic [SEG_W-1:0] seg,
			logic wr, logic unm);
		pager_cmd_t        r;
		logic [FLAG_W-1:0] f;
		logic [FLAG_W-1:0] nf;
		logic [63:0]       off;
		logic [63:0]       span;
		logic [SC_W-1:0]   live;
		r = '0;
		r.acc = ACC_KEEP;
		live = (cur_cfg.seg_count > SC_W'(MAX_SEGMENTS_DEF)) ? SC_W'(MAX_SEGMENTS_DEF)
			: cur_cfg.seg_count;
		if ({1'b0, seg} >= live) begin
			r.err = ERR_RANGE;
			return r;
		end
		f = seg_flags[seg];
		nf = f;
		off = 64'(seg) * 64'(cur_cfg.seg_bytes);
		case (act)
			ACT_FAULT: begin
				if (cur_cfg.prot == PROT_NO_ACCESS) begin
					r.err = ERR_NOACC;
				end else if (wr && !cur_cfg.prot[PROT_WR_BIT]) begin
					r.err = ERR_WRITE;
				end else if (f[FL_MAPPED] && (f[FL_DIRTY] == wr)) begin
					// already in the wanted state: leave alone
				end else begin
					r.load = !f[FL_MAPPED] && f[FL_NEEDREAD];
					r.acc = wr ? ACC_RW : ACC_RO;
					if (wr)
						nf[FL_DIRTY] = 1'b1;
					nf[FL_MAPPED] = 1'b1;
					r.notify = 1'b1;
				end
			end
			ACT_FLUSH: begin
				if (f[FL_DIRTY] && f[FL_MAPPED]) begin
					r.wb = 1'b1;
					nf[FL_DIRTY] = 1'b0;
					nf[FL_NEEDREAD] = 1'b1;
					if (cur_cfg.thread_safe)
						r.acc = ACC_RO;
				end
				if (f[FL_MAPPED]) begin
					if (unm == FLUSH_RELEASE) begin
						r.acc = ACC_NONE;
						r.rel = 1'b1;
						nf[FL_MAPPED] = 1'b0;
					end else if (!cur_cfg.thread_safe) begin
						r.acc = ACC_RO;
					end
				end
			end
			ACT_DROP: begin
				if (f[FL_MAPPED] && !f[FL_DIRTY]) begin
					r.acc = ACC_NONE;
					r.rel = 1'b1;
					nf[FL_MAPPED] = 1'b0;
				end
			end
			ACT_MARK: begin
				if (f[FL_MAPPED] && !f[FL_DIRTY] && cur_cfg.prot[PROT_WR_BIT]) begin
					r.acc = ACC_RW;
					nf[FL_DIRTY] = 1'b1;
				end
			end
			ACT_INIT: begin
				nf = cur_cfg.no_first_read ? '0 : FLAGS_RESET;
				r.acc = ACC_NONE;
			end
			default: begin
			end
		endcase
		seg_flags[seg] = nf;
		if (r.load || r.wb) begin
			span = 64'(cur_cfg.base) + off;
			r.offset = span[BASE_W-1:0];
			span = 64'(cur_cfg.map_bytes) - off;
			if (off >= 64'(cur_cfg.map_bytes))
				r.len = '0;
			else if (span >= 64'(cur_cfg.seg_bytes))
				r.len = cur_cfg.seg_bytes;
			else
				r.len = span[SB_W-1:0];
		end
		r.old_st = f[1:0];
		r.new_st = nf;
		return r;
	endfunction

	function automatic string describe_cmd(pager_cmd_t c);
		return $sformatf("ld=%0d wb=%0d rel=%0d acc=%0d off=%h len=%h ntf=%0d old=%0d new=%0d err=%0d",
			c.load, c.wb, c.rel, c.acc, c.offset, c.len, c.notify, c.old_st, c.new_st, c.err);
	endfunction

	task automatic check_result();
		pager_cmd_t got;
		pager_cmd_t want;
		got.load = load_segment;
		got.wb = write_back;
		got.rel = release_res;
		got.acc = access;
		got.offset = storage_offset;
		got.len = transfer_length;
		got.notify = notify_touch;
		got.old_st = old_status;
		got.new_st = new_status;
		got.err = error;
		results_seen++;
		if (expected_cmds.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("result %0d unexpected: got %s", results_seen, describe_cmd(got));
		end else begin
			want = expected_cmds.pop_front();
			if (got !== want) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("result %0d mismatch:\n  expected %s\n  actual   %s", results_seen,
						describe_cmd(want), describe_cmd(got));
			end
		end
	endtask

	// Sample the result channel on pre-edge values, then decide the next ready
	always @(posedge clk) begin
		if (out_valid && out_ready)
			check_result();
		if (hold_off_cycles > 0) begin
			hold_off_cycles--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_request(logic [ACT_W-1:0] act, logic [SEG_W-1:0] seg, logic wr, logic unm);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		segment <= seg;
		is_write <= wr;
		unmap <= unm;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_cmds.push_back(predict_pager_cmd(act, seg, wr, unm));
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_SEG_COUNT:     cur_cfg.seg_count = val[SC_W-1:0];
			REG_SEG_BYTES:     cur_cfg.seg_bytes = val[SB_W-1:0];
			REG_MAP_BYTES:     cur_cfg.map_bytes = val[MB_W-1:0];
			REG_STORAGE_BASE:  cur_cfg.base = val[BASE_W-1:0];
			REG_PROTECTION:    cur_cfg.prot = val[PROT_W-1:0];
			REG_THREAD_SAFE:   cur_cfg.thread_safe = val[0];
			REG_NO_FIRST_READ: cur_cfg.no_first_read = val[0];
			default: begin
			end
		endcase
	endtask

	// Drain every outstanding transaction before touching the registers
	task automatic apply_region_cfg(region_cfg_t c);
		in_valid <= 1'b0;
		while (expected_cmds.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(REG_SEG_COUNT, CFG_W'(c.seg_count));
		write_reg(REG_SEG_BYTES, CFG_W'(c.seg_bytes));
		write_reg(REG_MAP_BYTES, CFG_W'(c.map_bytes));
		write_reg(REG_STORAGE_BASE, CFG_W'(c.base));
		write_reg(REG_PROTECTION, CFG_W'(c.prot));
		write_reg(REG_THREAD_SAFE, CFG_W'(c.thread_safe));
		write_reg(REG_NO_FIRST_READ, CFG_W'(c.no_first_read));
		cfg_we <= 1'b0;
	endtask

	function automatic region_cfg_t random_region_cfg();
		region_cfg_t c;
		logic [63:0] wide;
		logic [63:0] product;
		int          pick;
		pick = $urandom_range(99);
		if (pick < 15)
			c.seg_count = SC_W'(MAX_SEGMENTS_DEF);
		else if (pick < 20)
			c.seg_count = '1;
		else if (pick < 30)
			c.seg_count = SC_W'(1);
		else
			c.seg_count = SC_W'($urandom_range(48, 2));
		pick = $urandom_range(99);
		if (pick < 20)
			c.seg_bytes = SB_W'(4096);
		else if (pick < 30)
			c.seg_bytes = 31'h4000_0000;
		else
			c.seg_bytes = SB_W'(4096 * $urandom_range(262144, 1));
		product = 64'((c.seg_count > SC_W'(MAX_SEGMENTS_DEF)) ? SC_W'(MAX_SEGMENTS_DEF)
			: c.seg_count) * 64'(c.seg_bytes);
		wide = {$urandom, $urandom};
		pick = $urandom_range(99);
		// often end the map inside the last segment so its transfer is clipped
		if (pick < 45)
			c.map_bytes = MB_W'(product - 64'($urandom_range(c.seg_bytes - 1, 0)));
		else if (pick < 60)
			c.map_bytes = MB_W'(product + 64'($urandom));
		else if (pick < 70)
			c.map_bytes = MB_W'(1);
		else if (pick < 80)
			c.map_bytes = 41'h100_0000_0000;
		else
			c.map_bytes = wide[MB_W-1:0] | MB_W'(1);
		wide = {$urandom, $urandom};
		pick = $urandom_range(99);
		if (pick < 20)
			c.base = '1;
		else if (pick < 35)
			c.base = '0;
		else
			c.base = wide[BASE_W-1:0];
		pick = $urandom_range(99);
		if (pick < 8)
			c.prot = PROT_NO_ACCESS;
		else if (pick < 20)
			c.prot = {1'($urandom_range(1)), 2'b01};
		else
			c.prot = PROT_W'($urandom_range(7, 1));
		c.thread_safe = 1'($urandom_range(1));
		c.no_first_read = 1'($urandom_range(1));
		return c;
	endfunction

	// Favour a few hot segments and the range boundary so the flags evolve
	function automatic logic [SEG_W-1:0] pick_segment();
		int live;
		int hot;
		int pick;
		live = (cur_cfg.seg_count > SC_W'(MAX_SEGMENTS_DEF)) ? MAX_SEGMENTS_DEF
			: int'(cur_cfg.seg_count);
		hot = (live < 12) ? live : 12;
		pick = $urandom_range(99);
		if (pick < 60)
			return SEG_W'($urandom_range(hot - 1, 0));
		if (pick < 75)
			return SEG_W'(live - 1 - int'($urandom_range(hot - 1, 0)));
		if (pick < 82)
			return SEG_W'(live);
		return SEG_W'($urandom);
	endfunction

	task automatic send_random_request();
		logic [ACT_W-1:0] act;
		int               pick;
		pick = $urandom_range(99);
		if (pick < 40)
			act = ACT_FAULT;
		else if (pick < 60)
			act = ACT_FLUSH;
		else if (pick < 70)
			act = ACT_DROP;
		else if (pick < 80)
			act = ACT_MARK;
		else if (pick < 88)
			act = ACT_INIT;
		else
			act = ACT_W'($urandom_range(ACT_UNUSED_HI, ACT_STATUS));
		send_request(act, pick_segment(), 1'($urandom_range(1)), $urandom_range(99) < 30);
	endtask

	task automatic test_reset_defaults();
		send_request(ACT_FAULT, 10'd0, 1'b0, 1'b0);
		send_request(ACT_FAULT, 10'd0, 1'b0, 1'b0);
		send_request(ACT_FAULT, 10'd0, 1'b1, 1'b0);
		// read on a mapped dirty segment: read-only, dirty kept
		send_request(ACT_FAULT, 10'd0, 1'b0, 1'b0);
		send_request(ACT_FLUSH, 10'd0, 1'b0, 1'b0);
		send_request(ACT_FAULT, 10'd1023, 1'b1, 1'b0);
		send_request(ACT_FLUSH, 10'd1023, 1'b0, FLUSH_RELEASE);
		send_request(ACT_FAULT, 10'd7, 1'b0, 1'b0);
		send_request(ACT_MARK, 10'd7, 1'b0, 1'b0);
		send_request(ACT_DROP, 10'd7, 1'b0, 1'b0);
		send_request(ACT_FLUSH, 10'd7, 1'b0, 1'b0);
		send_request(ACT_DROP, 10'd7, 1'b0, 1'b0);
		send_request(ACT_INIT, 10'd7, 1'b0, 1'b0);
		send_request(ACT_UNUSED_LO, 10'd7, 1'b1, 1'b1);
		send_request(ACT_UNUSED_HI, 10'd0, 1'b1, 1'b1);
	endtask

	task automatic test_config_corners();
		region_cfg_t c;
		// 1 GiB segments: offset wraps past the top, last transfer clipped to five bytes
		c.seg_count = SC_W'(2);
		c.seg_bytes = 31'h4000_0000;
		c.map_bytes = 41'h0_4000_0005;
		c.base = '1;
		c.prot = 3'b011;
		c.thread_safe = 1'b0;
		c.no_first_read = 1'b1;
		apply_region_cfg(c);
		send_request(ACT_INIT, 10'd1, 1'b0, 1'b0);
		send_request(ACT_FAULT, 10'd1, 1'b1, 1'b0);
		send_request(ACT_FLUSH, 10'd1, 1'b0, 1'b0);
		send_request(ACT_FAULT, 10'd2, 1'b0, 1'b0);
		send_request(ACT_STATUS, 10'd1023, 1'b0, 1'b0);
		// count above the parameter clamps; no access at all
		c.seg_count = '1;
		c.seg_bytes = SB_W'(4096);
		c.map_bytes = MB_W'(1);
		c.base = '0;
		c.prot = PROT_NO_ACCESS;
		c.thread_safe = 1'b1;
		c.no_first_read = 1'b0;
		apply_region_cfg(c);
		send_request(ACT_FAULT, 10'd1023, 1'b0, 1'b0);
		send_request(ACT_FAULT, 10'd1023, 1'b1, 1'b0);
		// read and execute only: writes refused, transfers beyond a one-byte map are empty
		c.seg_count = SC_W'(MAX_SEGMENTS_DEF);
		c.prot = 3'b101;
		apply_region_cfg(c);
		send_request(ACT_FAULT, 10'd3, 1'b1, 1'b0);
		send_request(ACT_FAULT, 10'd3, 1'b0, 1'b0);
		send_request(ACT_MARK, 10'd3, 1'b0, 1'b0);
		send_request(ACT_INIT, 10'd0, 1'b0, 1'b0);
		send_request(ACT_FAULT, 10'd0, 1'b0, 1'b0);
		send_request(ACT_FLUSH, 10'd0, 1'b0, FLUSH_RELEASE);
	endtask

	task automatic run_traffic_phase(int n_items, int send_pct, int recv_pct);
		apply_region_cfg(random_region_cfg());
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		repeat (n_items) send_random_request();
	endtask

	task automatic test_random_traffic();
		run_traffic_phase(190, 0, 0);
		run_traffic_phase(190, 67, 0);
		run_traffic_phase(190, 0, 67);
		run_traffic_phase(190, 10, 10);
		run_traffic_phase(190, 0, 0);
	endtask

	// Hold the result side off long enough for the pipeline to fill and stall input
	task automatic test_result_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 300;
		repeat (64) send_random_request();
	endtask

	initial begin
		foreach (seg_flags[i])
			seg_flags[i] = FLAGS_RESET;
		cur_cfg.seg_count = SC_W'(MAX_SEGMENTS_DEF);
		cur_cfg.seg_bytes = SB_W'(4096);
		cur_cfg.map_bytes = MB_W'(4194304);
		cur_cfg.base = '0;
		cur_cfg.prot = 3'b011;
		cur_cfg.thread_safe = 1'b1;
		cur_cfg.no_first_read = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_config_corners();
		test_random_traffic();
		test_result_backpressure();
		in_valid <= 1'b0;
		while (expected_cmds.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
